@@ rtl/mcdw_pkg.sv @@
`timescale 1ns / 1ps
package mcdw_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int COUNT_W    = 5;

	localparam logic [CFG_IDX_W-1:0] REG_ALIVE_MARGIN  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_ALLOWED = 1'd1;

	localparam logic [1:0] ACT_KEEPALIVE = 2'd0;
	localparam logic [1:0] ACT_CHECK     = 2'd1;
	localparam logic [1:0] ACT_RESET_REQ = 2'd2;

	localparam logic [CFG_DATA_W-1:0] ALIVE_MARGIN_RESET = 32'd1000000000;

	typedef struct packed {
		logic [1:0]         action;
		logic [7:0]         client_id;
		logic signed [63:0] deadline;
		logic signed [63:0] cur_time;
	} in_req_t;

	typedef struct packed {
		logic               accepted;
		logic [COUNT_W-1:0] monitored_count;
		logic [COUNT_W-1:0] alive_count;
		logic [COUNT_W-1:0] critical_count;
		logic [COUNT_W-1:0] dead_count;
		logic [7:0]         critical_client;
		logic signed [63:0] critical_offset;
		logic               timeout_alarm;
		logic               kick;
		logic               reset_granted;
	} out_rsp_t;

	typedef enum logic [1:0] {
		CLS_ALIVE,
		CLS_CRIT,
		CLS_DEAD
	} slot_class_t;

	// Counts stick at the top of their range.
	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
		logic [COUNT_W-1:0] r;
		r = (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
		return r;
	endfunction

endpackage

@@ rtl/mcdw_table.sv @@
`timescale 1ns / 1ps
module mcdw_table
	import mcdw_pkg::*;
#(
	parameter int SLOTS = 16,
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [7:0]       rd_client_q,
	output logic [63:0]      rd_deadline_q,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  logic [7:0]       wr_client,
	input  logic [63:0]      wr_deadline,
	output logic [SLOTS-1:0] used_q
);

	logic [7:0]  client_mem   [SLOTS];
	logic [63:0] deadline_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			client_mem[wr_idx]   <= wr_client;
			deadline_mem[wr_idx] <= wr_deadline;
		end
		rd_client_q   <= client_mem[rd_idx];
		rd_deadline_q <= deadline_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (wr_en) begin
			used_q[wr_idx] <= 1'b1;
		end
	end

endmodule

@@ rtl/mcdw_cmp.sv @@
`timescale 1ns / 1ps
module mcdw_cmp
	import mcdw_pkg::*;
(
	input  logic                  clk,
	input  logic                  en,
	input  logic [63:0]           deadline,
	input  logic [63:0]           cur_time,
	input  logic [CFG_DATA_W-1:0] margin,
	output slot_class_t           cls_q,
	output logic [63:0]           offset_q
);

	logic [64:0] diff;
	logic        dead;
	logic        alive;

	// Sign-extend so the difference is exact and never wraps.
	assign diff  = {deadline[63], deadline} - {cur_time[63], cur_time};
	assign dead  = diff[64] || (diff == '0);
	assign alive = !dead && (diff > {33'd0, margin});

	always_ff @(posedge clk) begin
		if (en) begin
			cls_q    <= dead ? CLS_DEAD : (alive ? CLS_ALIVE : CLS_CRIT);
			offset_q <= 64'd0 - diff[63:0];
		end
	end

endmodule

@@ rtl/multi_client_deadline_watchdog.sv @@
`timescale 1ns / 1ps
// Keepalive and check requests scan every table slot, one slot read per cycle through the
// shared compare unit; then the pipeline drains, the scan closes and the result is loaded
// into the output register. Reset and unused requests need no table access and go straight
// to the output register. One request is in flight at a time: in_stall stays high until the
// result is loaded, which waits while the previous result is still stalled at the output.
// Reset (arst_n low) frees every slot, sets alive_margin to 1000000000, disallows resets.
module multi_client_deadline_watchdog
	import mcdw_pkg::*;
#(
	parameter int TABLE_SLOTS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_req_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_rsp_t              out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_SLOTS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                state_q;
	in_req_t               req_q;
	out_rsp_t              res_q;
	out_rsp_t              out_q;
	logic                  out_valid_q;
	logic [CFG_DATA_W-1:0] margin_q;
	logic                  allow_q;

	// Scan sequencer: issue address, then table read stage, then compare stage.
	logic [CNT_W-1:0]      issue_q;
	logic                  v_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  v_s2;
	logic                  cnt_s2;
	logic [7:0]            client_s2;

	// Keepalive slot search.
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic                  free_q;
	logic [IDX_W-1:0]      free_idx_q;

	// Check accumulators.
	logic [COUNT_W-1:0]    mon_q;
	logic [COUNT_W-1:0]    alive_q;
	logic [COUNT_W-1:0]    crit_q;
	logic [COUNT_W-1:0]    dead_q;
	logic [7:0]            crit_id_q;
	logic [63:0]           crit_off_q;

	logic [7:0]            rd_client;
	logic [63:0]           rd_deadline;
	logic [TABLE_SLOTS-1:0] used;
	slot_class_t           cls;
	logic [63:0]           offset;

	logic                  issue_done;
	logic                  scan_end;
	logic                  is_keepalive;
	logic                  is_check;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_idx;
	logic                  slot_counted;

	assign issue_done   = (issue_q == LAST_CNT);
	assign scan_end     = (state_q == ST_SCAN) && issue_done && !v_s1 && !v_s2;
	assign is_keepalive = (req_q.action == ACT_KEEPALIVE);
	assign is_check     = (req_q.action == ACT_CHECK);
	// Store the keepalive once the whole table has been searched.
	assign wr_en        = scan_end && is_keepalive && (hit_q || free_q);
	assign wr_idx       = hit_q ? hit_idx_q : free_idx_q;
	assign slot_counted = used[idx_s1] && (rd_client != 8'd0);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	mcdw_table #(
		.SLOTS (TABLE_SLOTS),
		.IDX_W (IDX_W)
	) u_table (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd_idx        (issue_q[IDX_W-1:0]),
		.rd_client_q   (rd_client),
		.rd_deadline_q (rd_deadline),
		.wr_en         (wr_en),
		.wr_idx        (wr_idx),
		.wr_client     (req_q.client_id),
		.wr_deadline   (req_q.deadline),
		.used_q        (used)
	);

	// One shared subtract and compare handles every slot of a check.
	mcdw_cmp u_cmp (
		.clk      (clk),
		.en       (v_s1),
		.deadline (rd_deadline),
		.cur_time (req_q.cur_time),
		.margin   (margin_q),
		.cls_q    (cls),
		.offset_q (offset)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			margin_q    <= ALIVE_MARGIN_RESET;
			allow_q     <= 1'b0;
			issue_q     <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			v_s2        <= 1'b0;
			cnt_s2      <= 1'b0;
			client_s2   <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			mon_q       <= '0;
			alive_q     <= '0;
			crit_q      <= '0;
			dead_q      <= '0;
			crit_id_q   <= '0;
			crit_off_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ALIVE_MARGIN:  margin_q <= cfg_data;
					REG_RESET_ALLOWED: allow_q  <= cfg_data[0];
					default: ;
				endcase
			end

			// Advance the scan pipeline.
			v_s1      <= 1'b0;
			idx_s1    <= issue_q[IDX_W-1:0];
			v_s2      <= v_s1;
			cnt_s2    <= v_s1 && slot_counted;
			client_s2 <= rd_client;

			// Drop the result once the consumer takes it.
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q      <= in_data;
						issue_q    <= '0;
						hit_q      <= 1'b0;
						free_q     <= 1'b0;
						mon_q      <= '0;
						alive_q    <= '0;
						crit_q     <= '0;
						dead_q     <= '0;
						crit_id_q  <= '0;
						crit_off_q <= '0;
						res_q      <= '0;
						if (in_data.action == ACT_KEEPALIVE || in_data.action == ACT_CHECK) begin
							state_q <= ST_SCAN;
						end else begin
							// Reset requests and unused codes need no table access.
							res_q.reset_granted <= (in_data.action == ACT_RESET_REQ) && allow_q;
							state_q             <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (!issue_done) begin
						v_s1    <= 1'b1;
						issue_q <= issue_q + CNT_W'(1);
					end
					// Keepalive: first used slot with this id, else first free slot.
					if (v_s1 && is_keepalive) begin
						if (used[idx_s1]) begin
							if (!hit_q && rd_client == req_q.client_id) begin
								hit_q     <= 1'b1;
								hit_idx_q <= idx_s1;
							end
						end else if (!free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_s1;
						end
					end
					// Check: classify each counted slot; last critical one wins.
					if (v_s2 && cnt_s2 && is_check) begin
						mon_q <= sat_inc(mon_q);
						if (cls == CLS_DEAD) begin
							dead_q <= sat_inc(dead_q);
						end else if (cls == CLS_ALIVE) begin
							alive_q <= sat_inc(alive_q);
						end else begin
							crit_q     <= sat_inc(crit_q);
							crit_id_q  <= client_s2;
							crit_off_q <= offset;
						end
					end
					if (scan_end) begin
						if (is_keepalive) begin
							res_q.accepted <= hit_q || free_q;
						end else begin
							res_q.monitored_count <= mon_q;
							res_q.alive_count     <= alive_q;
							res_q.critical_count  <= crit_q;
							res_q.dead_count      <= dead_q;
							res_q.critical_client <= crit_id_q;
							res_q.critical_offset <= crit_off_q;
							res_q.timeout_alarm   <= (dead_q != '0);
							res_q.kick            <= 1'b1;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold until the output register is free.
					if (!out_valid_q || !out_stall) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ tb/multi_client_deadline_watchdog_test.sv @@
`timescale 1ns / 1ps
module multi_client_deadline_watchdog_test;
	import mcdw_pkg::*;

	localparam int NSLOT        = 16;
	localparam int POOL         = 24;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 30;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 700;
	localparam int PHASE_REQS   = 305;
	localparam int N_PHASES     = 6;

	localparam logic [1:0]         ACT_UNUSED = 2'd3;
	localparam logic signed [63:0] T_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] T_MIN      = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] JUNK_TIME  = 64'sh5A5A_5A5A_5A5A_5A5A;

	typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

	// One line of the directed plan: either a request or a register write.
	typedef struct {
		row_kind_t             kind;
		in_req_t               req;
		bit                    typed;
		out_rsp_t              want;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_req_t               in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_rsp_t              out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	multi_client_deadline_watchdog #(
		.TABLE_SLOTS(NSLOT)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow of the client table and registers, advanced once per accepted request.
	bit                    tbl_used     [NSLOT];
	logic [7:0]            tbl_client   [NSLOT];
	logic signed [63:0]    tbl_deadline [NSLOT];
	logic [CFG_DATA_W-1:0] mdl_margin;
	bit                    mdl_rst_ok;

	logic [7:0] id_pool [POOL];
	plan_row_t  plan_q [$];
	out_rsp_t   pending_rsp [$];
	out_rsp_t   head_rsp;

	int  burst_left;
	int  n_req, n_check, n_crit, n_alarm, n_refused, n_granted, n_fail;
	bit  hold_done;

	// Work out the answer to one request and update the shadow table.
	function automatic out_rsp_t predict_rsp(input in_req_t r);
		out_rsp_t    o;
		int          i, hit, free_idx;
		logic [63:0] lead;
		o = '0;
		case (r.action)
			ACT_KEEPALIVE: begin
				hit = -1;
				free_idx = -1;
				for (i = 0; i < NSLOT; i++) begin
					if (tbl_used[i]) begin
						if (hit < 0 && tbl_client[i] == r.client_id)
							hit = i;
					end else if (free_idx < 0) begin
						free_idx = i;
					end
				end
				if (hit < 0)
					hit = free_idx;
				if (hit >= 0) begin
					tbl_used[hit] = 1'b1;
					tbl_client[hit] = r.client_id;
					tbl_deadline[hit] = r.deadline;
					o.accepted = 1'b1;
				end
			end
			ACT_CHECK: begin
				for (i = 0; i < NSLOT; i++) begin
					if (tbl_used[i] && tbl_client[i] != 8'd0) begin
						o.monitored_count += COUNT_W'(1);
						if (tbl_deadline[i] <= r.cur_time) begin
							o.dead_count += COUNT_W'(1);
						end else begin
							// positive distance always fits unsigned 64 bits
							lead = tbl_deadline[i] - r.cur_time;
							if (lead > {32'd0, mdl_margin}) begin
								o.alive_count += COUNT_W'(1);
							end else begin
								o.critical_count += COUNT_W'(1);
								o.critical_client = tbl_client[i];
								o.critical_offset = r.cur_time - tbl_deadline[i];
							end
						end
					end
				end
				o.timeout_alarm = (o.dead_count != '0);
				o.kick = 1'b1;
			end
			ACT_RESET_REQ: begin
				o.reset_granted = mdl_rst_ok;
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic in_req_t mk_req(input logic [1:0] act, input logic [7:0] id,
			input logic signed [63:0] dl, input logic signed [63:0] now);
		in_req_t r;
		r.action = act;
		r.client_id = id;
		r.deadline = dl;
		r.cur_time = now;
		return r;
	endfunction

	function automatic void add_req(input in_req_t r, input bit typed, input out_rsp_t want);
		plan_row_t row;
		row.kind = ROW_REQ;
		row.req = r;
		row.typed = typed;
		row.want = want;
		row.reg_idx = '0;
		row.reg_val = '0;
		plan_q.push_back(row);
	endfunction

	function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		plan_row_t row;
		row.kind = ROW_CFG;
		row.req = '0;
		row.typed = 1'b0;
		row.want = '0;
		row.reg_idx = idx;
		row.reg_val = val;
		plan_q.push_back(row);
	endfunction

	// Times spread around a base, scaled to the margin so that all three classes show up.
	function automatic logic signed [63:0] near_base(input logic signed [63:0] base);
		longint span, off;
		span = longint'({32'd0, mdl_margin}) * 2 + 64;
		off = longint'({$urandom, $urandom}) % span;
		return base + off;
	endfunction

	function automatic logic signed [63:0] extreme_time();
		logic signed [63:0] t;
		case ($urandom_range(0, 3))
			0: t = T_MAX;
			1: t = T_MIN;
			2: t = 64'sd0;
			default: t = -64'sd1;
		endcase
		return t;
	endfunction

	// Build one random request; unused fields stay random on purpose.
	function automatic in_req_t rand_req(input logic signed [63:0] base);
		in_req_t     r;
		int          pick, k;
		logic [63:0] delta;
		r.client_id = 8'($urandom);
		r.deadline = {$urandom, $urandom};
		r.cur_time = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, NSLOT - 1);
		if (pick < 45) begin
			r.action = ACT_KEEPALIVE;
			r.client_id = id_pool[$urandom_range(0, POOL - 1)];
			case ($urandom_range(0, 9))
				0: begin
				end
				1: r.deadline = extreme_time();
				default: r.deadline = near_base(base);
			endcase
		end else if (pick < 85) begin
			r.action = ACT_CHECK;
			case ($urandom_range(0, 9))
				0: begin
				end
				1: r.cur_time = extreme_time();
				2, 3, 4, 5: begin
					if (tbl_used[k]) begin
						// land right on a class border of a stored client
						case ($urandom_range(0, 4))
							0: delta = 64'd0;
							1: delta = 64'd1;
							2: delta = {32'd0, mdl_margin};
							3: delta = {32'd0, mdl_margin} + 64'd1;
							default: delta = '1;
						endcase
						r.cur_time = tbl_deadline[k] - delta;
					end else begin
						r.cur_time = near_base(base);
					end
				end
				default: r.cur_time = near_base(base);
			endcase
		end else if (pick < 95) begin
			r.action = ACT_RESET_REQ;
		end else begin
			r.action = ACT_UNUSED;
		end
		return r;
	endfunction

	// Offer one request, wait for the handshake, then record what must come back.
	task automatic offer(input in_req_t r, input bit typed, input out_rsp_t want);
		out_rsp_t pred;
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pred = predict_rsp(r);
		pending_rsp.push_back(typed ? want : pred);
		n_req++;
		case (r.action)
			ACT_KEEPALIVE: if (!pred.accepted) n_refused++;
			ACT_CHECK: begin
				n_check++;
				if (pred.critical_count != '0)
					n_crit++;
				if (pred.timeout_alarm)
					n_alarm++;
			end
			ACT_RESET_REQ: if (pred.reset_granted) n_granted++;
			default: begin
			end
		endcase
		// end of a burst: drop valid for a short random gap
		burst_left--;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 12);
		end
	endtask

	// Write a register only once the block has answered everything and gone quiet.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		if (in_valid)
			in_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ALIVE_MARGIN)
			mdl_margin = val;
		else if (idx == REG_RESET_ALLOWED)
			mdl_rst_ok = val[0];
	endtask

	task automatic build_directed();
		out_rsp_t e;
		// empty table: a check still kicks and nothing else
		e = '0;
		e.kick = 1'b1;
		add_req(mk_req(ACT_CHECK, 8'hA5, JUNK_TIME, 64'sd0), 1'b1, e);
		// reset request while resets are still locked out, then an unused action
		e = '0;
		add_req(mk_req(ACT_RESET_REQ, 8'hFF, T_MAX, T_MIN), 1'b1, e);
		add_req(mk_req(ACT_UNUSED, 8'h5A, -64'sd1, -64'sd1), 1'b1, e);
		// id zero and the deadline extremes all get stored
		e.accepted = 1'b1;
		add_req(mk_req(ACT_KEEPALIVE, 8'd0, T_MAX, JUNK_TIME), 1'b1, e);
		add_req(mk_req(ACT_KEEPALIVE, 8'd255, T_MIN, JUNK_TIME), 1'b1, e);
		add_req(mk_req(ACT_KEEPALIVE, 8'd7, 64'sd1000, JUNK_TIME), 1'b1, e);
		// now 0: 255 dead, 7 critical by 1000, id zero skipped
		e = '0;
		e.monitored_count = 5'd2;
		e.critical_count = 5'd1;
		e.dead_count = 5'd1;
		e.critical_client = 8'd7;
		e.critical_offset = -64'sd1000;
		e.timeout_alarm = 1'b1;
		e.kick = 1'b1;
		add_req(mk_req(ACT_CHECK, 8'hA5, JUNK_TIME, 64'sd0), 1'b1, e);
		// latest possible time: everyone dead
		e = '0;
		e.monitored_count = 5'd2;
		e.dead_count = 5'd2;
		e.timeout_alarm = 1'b1;
		e.kick = 1'b1;
		add_req(mk_req(ACT_CHECK, 8'h00, JUNK_TIME, T_MAX), 1'b1, e);
		// earliest possible time: equal deadline is dead, the far one alive
		e.dead_count = 5'd1;
		e.alive_count = 5'd1;
		add_req(mk_req(ACT_CHECK, 8'hFF, -64'sd1, T_MIN), 1'b1, e);
		add_cfg(REG_RESET_ALLOWED, 32'd1);
		e = '0;
		e.reset_granted = 1'b1;
		add_req(mk_req(ACT_RESET_REQ, 8'h00, T_MIN, T_MAX), 1'b1, e);
		// zero margin: one unit ahead is already alive
		add_cfg(REG_ALIVE_MARGIN, 32'd0);
		add_req(mk_req(ACT_CHECK, 8'hA5, JUNK_TIME, 64'sd999), 1'b0, '0);
		add_req(mk_req(ACT_CHECK, 8'hA5, JUNK_TIME, 64'sd1000), 1'b0, '0);
		// widest margin: border sits exactly at 2^32 - 1
		add_cfg(REG_ALIVE_MARGIN, 32'hFFFF_FFFF);
		e = '0;
		e.accepted = 1'b1;
		add_req(mk_req(ACT_KEEPALIVE, 8'd7, 64'sh1_0000_0000, JUNK_TIME), 1'b1, e);
		add_req(mk_req(ACT_CHECK, 8'h5A, JUNK_TIME, 64'sd0), 1'b0, '0);
		add_req(mk_req(ACT_CHECK, 8'h5A, JUNK_TIME, 64'sd1), 1'b0, '0);
		// move id zero next to now; it must stay out of every count
		add_req(mk_req(ACT_KEEPALIVE, 8'd0, 64'sd5, JUNK_TIME), 1'b0, '0);
		add_req(mk_req(ACT_CHECK, 8'hA5, JUNK_TIME, 64'sd0), 1'b0, '0);
		add_req(mk_req(ACT_KEEPALIVE, 8'd128, T_MAX, JUNK_TIME), 1'b0, '0);
		add_req(mk_req(ACT_CHECK, 8'hA5, JUNK_TIME, T_MAX - 64'sd1), 1'b0, '0);
		add_cfg(REG_RESET_ALLOWED, 32'd0);
		add_req(mk_req(ACT_RESET_REQ, 8'hFF, T_MAX, T_MIN), 1'b0, '0);
	endtask

	task automatic cmp_field(input string fname, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, fname, want, got);
			n_fail++;
		end
	endtask

	// Compare every accepted result with the oldest outstanding expectation.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid && !out_stall) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: result with none expected, expected nothing, got %h",
					$time, out_data);
				n_fail++;
			end else begin
				head_rsp = pending_rsp.pop_front();
				cmp_field("accepted", 64'(head_rsp.accepted), 64'(out_data.accepted));
				cmp_field("monitored_count", 64'(head_rsp.monitored_count),
					64'(out_data.monitored_count));
				cmp_field("alive_count", 64'(head_rsp.alive_count),
					64'(out_data.alive_count));
				cmp_field("critical_count", 64'(head_rsp.critical_count),
					64'(out_data.critical_count));
				cmp_field("dead_count", 64'(head_rsp.dead_count),
					64'(out_data.dead_count));
				cmp_field("critical_client", 64'(head_rsp.critical_client),
					64'(out_data.critical_client));
				cmp_field("critical_offset", head_rsp.critical_offset, out_data.critical_offset);
				cmp_field("timeout_alarm", 64'(head_rsp.timeout_alarm),
					64'(out_data.timeout_alarm));
				cmp_field("kick", 64'(head_rsp.kick), 64'(out_data.kick));
				cmp_field("reset_granted", 64'(head_rsp.reset_granted),
					64'(out_data.reset_granted));
			end
		end
	end

	// Receiver: stall in segments of varying density, plus one long hold-off
	// while the sender keeps offering, so the block backs up into in_stall.
	initial begin : rsp_stall_gen
		int mode;
		out_stall <= 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && n_req >= HOLD_AFTER) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(10, 120)) begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
				@(posedge clk);
			end
		end
	end

	// Abort if neither side moves a request for too long.
	initial begin : stall_guard
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
		$display("[multi_client_deadline_watchdog] ERROR");
		$finish;
	end

	initial begin : stimulus
		int                    ph;
		logic signed [63:0]    base;
		logic [CFG_DATA_W-1:0] margin_val;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n = 1'b0;
		n_req = 0;
		n_check = 0;
		n_crit = 0;
		n_alarm = 0;
		n_refused = 0;
		n_granted = 0;
		n_fail = 0;
		burst_left = $urandom_range(1, 12);
		for (int i = 0; i < NSLOT; i++) begin
			tbl_used[i] = 1'b0;
			tbl_client[i] = 8'd0;
			tbl_deadline[i] = 64'sd0;
		end
		mdl_margin = ALIVE_MARGIN_RESET;
		mdl_rst_ok = 1'b0;
		// more ids than slots, so the table fills and later ids get refused
		id_pool[0] = 8'd0;
		id_pool[1] = 8'd255;
		for (int i = 2; i < POOL; i++)
			id_pool[i] = 8'($urandom_range(1, 254));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan first
		build_directed();
		foreach (plan_q[i]) begin
			if (plan_q[i].kind == ROW_CFG)
				write_reg(plan_q[i].reg_idx, plan_q[i].reg_val);
			else
				offer(plan_q[i].req, plan_q[i].typed, plan_q[i].want);
		end

		// random phases, each with its own margin, reset permission and time base
		for (ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: margin_val = $urandom;
				1: margin_val = 32'd1;
				2: margin_val = 32'hFFFF_FFFF;
				3: margin_val = 32'd0;
				4: margin_val = 32'd5000;
				default: margin_val = ALIVE_MARGIN_RESET;
			endcase
			write_reg(REG_ALIVE_MARGIN, margin_val);
			write_reg(REG_RESET_ALLOWED, (ph % 2 == 0) ? 32'd1 : 32'd0);
			case (ph)
				2: base = T_MAX - 64'sd4_000_000_000;
				3: base = T_MIN + 64'sd100;
				default: base = {$urandom, $urandom};
			endcase
			repeat (PHASE_REQS)
				offer(rand_req(base), 1'b0, '0);
		end

		// drain and let any stray result show up
		if (in_valid)
			in_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests: %0d checks, %0d with critical clients, %0d with alarms",
			n_req, n_check, n_crit, n_alarm);
		$display("%0d keepalives refused on a full table, %0d resets granted, %0d mismatches",
			n_refused, n_granted, n_fail);
		if (n_fail == 0)
			$display("[multi_client_deadline_watchdog] OK");
		else
			$display("[multi_client_deadline_watchdog] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/mcdw_pkg.sv
rtl/mcdw_table.sv
rtl/mcdw_cmp.sv
rtl/multi_client_deadline_watchdog.sv
tb/multi_client_deadline_watchdog_test.sv
